### hdl/mf3_pkg.sv
// Shared types and constants for the 3x3 RGB median filter.
// No dependencies; imported by both design files and both test files.
`default_nettype none

package mf3_pkg;

   localparam int PIX_W     = 8;                  // bits per colour sample
   localparam int NUM_CH    = 3;                  // blue, green, red
   localparam int COL_PIX   = 3;                  // top, mid, bot
   localparam int COL_BYTES = COL_PIX * NUM_CH;   // samples in one column beat
   localparam int TAPS      = 9;                  // window samples per channel
   localparam int MED_RANK  = 4;                  // fifth smallest of nine

   localparam int IN_DATA_W  = COL_BYTES * PIX_W;
   localparam int OUT_DATA_W = NUM_CH * PIX_W;

   typedef logic [PIX_W-1:0] pix_type;
   typedef pix_type [TAPS-1:0] tap_array_type;
   typedef pix_type [COL_BYTES-1:0] column_type;

   // load enables of the two registered sorting stages
   typedef struct packed {
      logic s1;
      logic s2;
   } stage_en_type;

endpackage : mf3_pkg

`default_nettype wire

### hdl/mf3_lane.sv
// One channel's median-of-nine network, cut into two registered stages.
// Depends on mf3_pkg; instantiated once per colour by median_filter_3x3_rgb.
`default_nettype none

module mf3_lane
   import mf3_pkg::*;
(
   input  wire logic          clock,
   input  wire stage_en_type  en,
   input  wire tap_array_type taps,
   output      pix_type       med
);

   tap_array_type s1_in, s1_ff;
   tap_array_type s2_in, s2_ff;
   tap_array_type tail;

   // compare-exchange: smaller value ends up at index a
   function automatic tap_array_type cas(input tap_array_type v, input int a, input int b);
      pix_type t;
      tap_array_type r;
      r = v;
      if (v[b] < v[a]) begin
         t    = r[a];
         r[a] = r[b];
         r[b] = t;
      end
      return r;
   endfunction

   // rows sorted in triples
   always_comb begin
      s1_in = taps;
      s1_in = cas(s1_in, 1, 2);
      s1_in = cas(s1_in, 4, 5);
      s1_in = cas(s1_in, 7, 8);
      s1_in = cas(s1_in, 0, 1);
      s1_in = cas(s1_in, 3, 4);
      s1_in = cas(s1_in, 6, 7);
      s1_in = cas(s1_in, 1, 2);
      s1_in = cas(s1_in, 4, 5);
      s1_in = cas(s1_in, 7, 8);
   end

   always_comb begin
      s2_in = s1_ff;
      s2_in = cas(s2_in, 0, 3);
      s2_in = cas(s2_in, 5, 8);
      s2_in = cas(s2_in, 4, 7);
      s2_in = cas(s2_in, 3, 6);
      s2_in = cas(s2_in, 1, 4);
      s2_in = cas(s2_in, 2, 5);
      s2_in = cas(s2_in, 4, 7);
   end

   // final narrowing onto the centre element
   always_comb begin
      tail = s2_ff;
      tail = cas(tail, 2, 4);
      tail = cas(tail, 4, 6);
      tail = cas(tail, 2, 4);
   end

   assign med = tail[MED_RANK];

   always_ff @(posedge clock) begin
      if (en.s1) begin
         s1_ff <= s1_in;
      end
      if (en.s2) begin
         s2_ff <= s2_in;
      end
   end

endmodule : mf3_lane

`default_nettype wire

### hdl/median_filter_3x3_rgb.sv
// Top level of the 3x3 RGB median filter: column window, lane pipeline, output register.
// Depends on mf3_pkg and mf3_lane.
`default_nettype none

// Takes one image column per beat (three stacked BGR pixels) and returns, one beat
// per input beat, the per-channel median of the 3x3 window formed with the two
// previous columns of the row. req_tuser marks the first column of a row; columns
// not yet seen in a row count as zero pixels and rsp_tuser stays low until the
// third column. Sustained rate is one column per clock while rsp_tready stays high;
// each result is registered in the two sorting-network stages and then the output
// register. Each stage stalls only when it holds data that cannot move on.

module median_filter_3x3_rgb
   import mf3_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // top_blue, top_green, top_red, mid_blue, mid_green, mid_red,
   // bot_blue, bot_green, bot_red (8 bits each, from bit 0)
   input  wire logic [IN_DATA_W-1:0]  req_tdata,
   input  wire logic                  req_tuser,   // row_start
   input  wire logic                  req_tvalid,
   output      logic                  req_tready,
   // med_blue, med_green, med_red (8 bits each, from bit 0)
   output      logic [OUT_DATA_W-1:0] rsp_tdata,
   output      logic                  rsp_tuser,   // window_full
   output      logic                  rsp_tvalid,
   input  wire logic                  rsp_tready
);

   column_type col_old_ff, col_old_in;
   column_type col_new_ff, col_new_in;
   column_type fresh;
   logic [1:0] seen_ff, seen_in;
   logic       accept;

   logic v1_ff, v1_in, v2_ff, v2_in;
   logic full1_ff, full2_ff;
   logic rdy1, rdy2, rdy_o;
   stage_en_type en;

   logic                  rsp_tvalid_ff, rsp_tvalid_in;
   logic [OUT_DATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;
   logic                  rsp_tuser_ff;

   tap_array_type   taps [NUM_CH];
   pix_type         med  [NUM_CH];

   // ---- handshake chain
   assign rdy_o      = !rsp_tvalid_ff || rsp_tready;
   assign rdy2       = !v2_ff || rdy_o;
   assign rdy1       = !v1_ff || rdy2;
   assign req_tready = rdy1;
   assign accept     = req_tvalid && rdy1;
   assign en.s1      = rdy1;
   assign en.s2      = rdy2;

   assign v1_in         = rdy1  ? req_tvalid : v1_ff;
   assign v2_in         = rdy2  ? v1_ff      : v2_ff;
   assign rsp_tvalid_in = rdy_o ? v2_ff      : rsp_tvalid_ff;

   // ---- column window
   always_comb begin
      for (int i = 0; i < COL_BYTES; i++) begin
         fresh[i] = req_tdata[i*PIX_W +: PIX_W];
      end
   end

   always_comb begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
         for (int k = 0; k < COL_PIX; k++) begin
            taps[ch][k*3]     = req_tuser ? '0 : col_old_ff[k*NUM_CH + ch];
            taps[ch][k*3 + 1] = req_tuser ? '0 : col_new_ff[k*NUM_CH + ch];
            taps[ch][k*3 + 2] = fresh[k*NUM_CH + ch];
         end
      end
   end

   always_comb begin
      col_old_in = col_old_ff;
      col_new_in = col_new_ff;
      seen_in    = seen_ff;
      if (accept) begin
         col_old_in = req_tuser ? '0 : col_new_ff;
         col_new_in = fresh;
         priority if (req_tuser) begin
            seen_in = 2'd1;
         end else if (seen_ff == 2'd3) begin
            seen_in = 2'd3;
         end else begin
            seen_in = seen_ff + 2'd1;
         end
      end
   end

   // ---- lanes, one per colour
   for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_lane
      mf3_lane u_lane (
         .clock (clock),
         .en    (en),
         .taps  (taps[ch]),
         .med   (med[ch])
      );
   end

   // ---- merge into the output beat
   always_comb begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
         rsp_tdata_in[ch*PIX_W +: PIX_W] = med[ch];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_old_ff    <= '0;
         col_new_ff    <= '0;
         seen_ff       <= '0;
         v1_ff         <= 1'b0;
         v2_ff         <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         col_old_ff    <= col_old_in;
         col_new_ff    <= col_new_in;
         seen_ff       <= seen_in;
         v1_ff         <= v1_in;
         v2_ff         <= v2_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         full1_ff <= (seen_in == 2'd3);
      end
      if (rdy2) begin
         full2_ff <= full1_ff;
      end
      if (rdy_o) begin
         rsp_tdata_ff <= rsp_tdata_in;
         rsp_tuser_ff <= full2_ff;
      end
   end

   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;
   assign rsp_tvalid = rsp_tvalid_ff;

`ifndef SYNTHESIS
   // a row start always restarts the column count at one
   a_row_restart : assert property (@(posedge clock) disable iff (reset)
      accept && req_tuser |=> seen_ff == 2'd1)
      else $error("column count not restarted on row start");

   // input only back-pressured when every stage holds a beat and the sink stalls
   a_no_bubble_stall : assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> v1_ff && v2_ff && rsp_tvalid_ff && !rsp_tready)
      else $error("input stalled while the pipeline has room");

   // pipeline empties on reset
   a_reset_empty : assert property (@(posedge clock)
      reset |=> !v1_ff && !v2_ff && !rsp_tvalid_ff)
      else $error("pipeline holds beats after reset");

   // a beat leaving stage two lands in the output register
   a_stage_to_out : assert property (@(posedge clock) disable iff (reset)
      v2_ff && rdy_o |=> rsp_tvalid_ff)
      else $error("beat lost between sorting stage and output");
`endif

endmodule : median_filter_3x3_rgb

`default_nettype wire

### test/median_checker.sv
// Checker for median_filter_3x3_rgb: watches both streams, predicts each result beat.
// Depends on mf3_pkg; instantiated beside the block by tb_top.
`default_nettype none

module median_checker
   import mf3_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [IN_DATA_W-1:0]  req_tdata,
   input  wire logic                  req_tuser,
   input  wire logic                  req_tvalid,
   input  wire logic                  req_tready,
   input  wire logic [OUT_DATA_W-1:0] rsp_tdata,
   input  wire logic                  rsp_tuser,
   input  wire logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   output      int                    errors,
   output      int                    outstanding,
   output      int                    checked
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int BLUE  = 0;
   localparam int GREEN = 1;
   localparam int RED   = 2;

   typedef struct packed {
      pix_type med_blue;
      pix_type med_green;
      pix_type med_red;
      logic    window_full;
   } filtered_pixel_t;

   // two previous columns of the row and the column count, saturating at 3
   column_type older_col;
   column_type newer_col;
   logic [1:0] cols_in_row;

   filtered_pixel_t median_q[$];

   initial begin
      errors      = 0;
      outstanding = 0;
      checked     = 0;
   end

   function automatic pix_type middle_of_nine(input tap_array_type taps);
      tap_array_type s;
      pix_type       t;
      s = taps;
      for (int i = 1; i < TAPS; i++) begin
         for (int j = i; j > 0 && s[j] < s[j-1]; j--) begin
            t      = s[j];
            s[j]   = s[j-1];
            s[j-1] = t;
         end
      end
      return s[MED_RANK];
   endfunction

   // advances the window by one column and returns the filtered pixel
   function automatic filtered_pixel_t filter_column(input column_type fresh, input logic start);
      filtered_pixel_t res;
      tap_array_type   taps;
      pix_type         med [NUM_CH];
      if (start) begin
         older_col = '0;
         newer_col = '0;
      end
      for (int ch = 0; ch < NUM_CH; ch++) begin
         for (int r = 0; r < COL_PIX; r++) begin
            taps[r*3]     = older_col[r*NUM_CH + ch];
            taps[r*3 + 1] = newer_col[r*NUM_CH + ch];
            taps[r*3 + 2] = fresh[r*NUM_CH + ch];
         end
         med[ch] = middle_of_nine(taps);
      end
      if (start)
         cols_in_row = 2'd1;
      else if (cols_in_row != 2'd3)
         cols_in_row = cols_in_row + 2'd1;
      res.med_blue    = med[BLUE];
      res.med_green   = med[GREEN];
      res.med_red     = med[RED];
      res.window_full = (cols_in_row == 2'd3);
      older_col = newer_col;
      newer_col = fresh;
      return res;
   endfunction

   always @(posedge clock) begin
      filtered_pixel_t want;
      pix_type         got_blue;
      pix_type         got_green;
      pix_type         got_red;
      if (reset) begin
         older_col   = '0;
         newer_col   = '0;
         cols_in_row = '0;
         median_q.delete();
      end else begin
         if (req_tvalid && req_tready)
            median_q.push_back(filter_column(req_tdata, req_tuser));
         if (rsp_tvalid && rsp_tready) begin
            got_blue  = rsp_tdata[BLUE*PIX_W  +: PIX_W];
            got_green = rsp_tdata[GREEN*PIX_W +: PIX_W];
            got_red   = rsp_tdata[RED*PIX_W   +: PIX_W];
            if (median_q.size() == 0) begin
               $error("result beat with nothing pending: tdata %h tuser %b",
                      rsp_tdata, rsp_tuser);
               errors <= errors + 1;
            end else begin
               want = median_q.pop_front();
               if (got_blue !== want.med_blue)
                  $error("med_blue: expected %0d, got %0d", want.med_blue, got_blue);
               if (got_green !== want.med_green)
                  $error("med_green: expected %0d, got %0d", want.med_green, got_green);
               if (got_red !== want.med_red)
                  $error("med_red: expected %0d, got %0d", want.med_red, got_red);
               if (rsp_tuser !== want.window_full)
                  $error("window_full: expected %b, got %b", want.window_full, rsp_tuser);
               if (got_blue !== want.med_blue || got_green !== want.med_green ||
                   got_red !== want.med_red || rsp_tuser !== want.window_full)
                  errors <= errors + 1;
               checked <= checked + 1;
            end
         end
      end
      outstanding <= median_q.size();
   end

endmodule : median_checker

`default_nettype wire

### test/tb_top.sv
// Testbench top for median_filter_3x3_rgb: clock, reset, column stimulus and verdict.
// Depends on mf3_pkg, median_filter_3x3_rgb and median_checker.
`default_nettype none

module tb_top;
   import mf3_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum int {MIX_ANY, MIX_TIES, MIX_RAILS} pixel_mix_t;
   typedef enum int {SINK_FREE, SINK_COIN, SINK_SLOW, SINK_HOLD} sink_mode_t;

   localparam int RANDOM_COLUMNS = 600;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic [IN_DATA_W-1:0]  req_tdata  = '0;
   logic                  req_tuser  = 1'b0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [OUT_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;

   int errors;
   int outstanding;
   int checked;
   int columns_sent = 0;
   int rows_sent    = 0;
   int burst_left   = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   median_filter_3x3_rgb u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   median_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .errors      (errors),
      .outstanding (outstanding),
      .checked     (checked)
   );

   // receiver: stretches of free flow, coin-toss, sparse acceptance and full hold
   always @(posedge clock) begin
      sink_mode_t sink_mode;
      int         sink_left;
      if (reset) begin
         rsp_tready <= 1'b0;
         sink_left = 0;
      end else begin
         if (sink_left == 0) begin
            sink_mode = sink_mode_t'($urandom_range(SINK_FREE, SINK_HOLD));
            sink_left = $urandom_range(4, 40);
         end
         sink_left--;
         case (sink_mode)
            SINK_FREE: rsp_tready <= 1'b1;
            SINK_COIN: rsp_tready <= 1'($urandom_range(0, 1));
            SINK_SLOW: rsp_tready <= ($urandom_range(0, 3) == 0);
            default:   rsp_tready <= 1'b0;
         endcase
      end
   end

   function automatic column_type flat_column(input pix_type b, input pix_type g,
                                              input pix_type r);
      column_type col;
      for (int p = 0; p < COL_PIX; p++)
         col[p*NUM_CH +: NUM_CH] = {r, g, b};
      return col;
   endfunction

   function automatic column_type random_column(input pixel_mix_t mix);
      column_type col;
      for (int k = 0; k < COL_BYTES; k++) begin
         case (mix)
            MIX_TIES:  col[k] = 8'(($urandom_range(0, 1) ? 252 : 0) + $urandom_range(0, 3));
            MIX_RAILS: col[k] = $urandom_range(0, 1) ? 8'hff : 8'h00;
            default:   col[k] = 8'($urandom_range(0, 255));
         endcase
      end
      return col;
   endfunction

   // one beat on the request side, opening a fresh burst after a random gap when due
   task automatic send_column(input column_type col, input logic start);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tdata  <= col;
      req_tuser  <= start;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      columns_sent++;
      if (start)
         rows_sent++;
   endtask

   task automatic drain;
      req_tvalid <= 1'b0;
      burst_left = 0;
      // the pending count is a registered copy of the checker's queue size
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   initial begin
      column_type col;
      int         row_len;
      bit         pressed;

      pressed = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // continuing row straight out of reset: missing columns are zero pixels
      send_column(flat_column(8'hff, 8'hff, 8'hff), 1'b0);
      send_column(flat_column(8'hff, 8'hff, 8'hff), 1'b0);
      send_column(flat_column(8'h00, 8'h80, 8'hff), 1'b0);
      send_column(flat_column(8'h01, 8'h02, 8'h03), 1'b0);
      send_column(flat_column(8'h55, 8'haa, 8'h7f), 1'b0);
      // row start clears the window even though the count had saturated
      send_column(flat_column(8'hff, 8'hff, 8'hff), 1'b1);
      col = '0;
      col[0] = 8'hff; col[4] = 8'hff; col[8] = 8'hff;
      col[1] = 8'haa; col[5] = 8'h55; col[6] = 8'h80;
      send_column(col, 1'b0);
      // restart after two columns, then again after one
      send_column(flat_column(8'h80, 8'h80, 8'h80), 1'b1);
      send_column(flat_column(8'h10, 8'hf0, 8'h01), 1'b1);
      send_column(flat_column(8'h07, 8'h07, 8'h07), 1'b0);
      send_column(flat_column(8'h07, 8'h07, 8'h07), 1'b0);
      send_column(flat_column(8'h07, 8'h07, 8'h07), 1'b0);
      // full window with distinct samples and ties per channel
      send_column(random_column(MIX_ANY), 1'b1);
      send_column(random_column(MIX_TIES), 1'b0);
      send_column(random_column(MIX_RAILS), 1'b0);
      send_column(flat_column(8'h00, 8'h00, 8'h00), 1'b0);
      send_column(flat_column(8'hff, 8'hff, 8'hff), 1'b0);
      send_column(flat_column(8'hfe, 8'h01, 8'h80), 1'b0);
      drain();

      // random rows: mostly well formed, some restarts mid-row and rows without a start
      while (columns_sent < RANDOM_COLUMNS + 18) begin
         row_len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 40);
         for (int c = 0; c < row_len; c++) begin
            logic start;
            start = (c == 0);
            if ($urandom_range(0, 19) == 0)
               start = ~start;
            send_column(random_column(pixel_mix_t'($urandom_range(MIX_ANY, MIX_RAILS))),
                        start);
         end
         if (!pressed && columns_sent > 300) begin
            pressed = 1'b1;
            drain();
         end
      end
      drain();

      $display("covered %0d columns in %0d started rows, %0d result beats checked",
               columns_sent, rows_sent, checked);
      $display("with row restarts, zero-filled windows, ties and rail values on every channel");
      if (errors == 0 && outstanding == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #2ms;
      $display("timed out with %0d results outstanding", outstanding);
      $display("status: fail");
      $finish;
   end

endmodule : tb_top

`default_nettype wire
